[design/lru_cache_with_next_line_prefetch_top_defines.svh]
// Assertion macros for the cache RTL.
`ifndef LRU_CACHE_WITH_NEXT_LINE_PREFETCH_TOP_DEFINES_SVH
`define LRU_CACHE_WITH_NEXT_LINE_PREFETCH_TOP_DEFINES_SVH
`ifndef SYNTH
`define LCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cache assertion failed");
`define LCP_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cache assertion failed");
`else
`define LCP_ASSERT(lbl, prop)
`define LCP_ASSERT_NORST(lbl, prop)
`endif
`endif

[design/lcp_pkg.sv]
`default_nettype none
package lcp_pkg;

  localparam int AGE_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [AGE_W-1:0] AGE_MAX = 4'd15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFETCH    = 2'd3;

  // configuration reset values
  localparam logic [3:0] RST_OFFSET_BITS = 4'd4;
  localparam logic [3:0] RST_INDEX_BITS  = 4'd6;
  localparam logic [4:0] RST_WAYS        = 5'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CMP,
    S_UPD,
    S_FIN
  } lcp_state_t;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic cmp;
    logic upd;
    logic pf;
    logic finish;
  } lcp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic hit;
    logic pf_en;
    logic out_free;
  } lcp_sts_t;

endpackage
`default_nettype wire

[design/lcp_ctrl.sv]
`default_nettype none
module lcp_ctrl
  import lcp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire lcp_sts_t sts,
  output lcp_cmd_t      cmd
);

  lcp_state_t state_r, state_nxt;
  logic       pf_r, pf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pf_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pf_r    <= pf_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pf_nxt    = pf_r;
    unique case (state_r)
      S_CLEAR: if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        pf_nxt = 1'b0;
        if (in_valid) state_nxt = S_RD;
      end
      S_RD:  state_nxt = S_CMP;
      S_CMP: state_nxt = S_UPD;
      S_UPD: begin
        // demand miss with prefetch on: second pass for the next block
        if (!pf_r && !sts.hit && sts.pf_en) begin
          state_nxt = S_RD;
          pf_nxt    = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.pf     = pf_r;
    in_stall   = 1'b1;
    unique case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_RD:  cmd.rd  = 1'b1;
      S_CMP: cmd.cmp = 1'b1;
      S_UPD: cmd.upd = 1'b1;
      S_FIN: cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/lcp_dp.sv]
`default_nettype none
module lcp_dp
  import lcp_pkg::*;
#(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 16,
  parameter int ADDR_BITS = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_action,
  input  wire logic [ADDR_BITS-1:0]  in_address,
  input  wire lcp_cmd_t              cmd,
  output lcp_sts_t                   sts,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [1:0]                 out_reads_caused,
  output logic                       out_write_caused,
  output logic [31:0]                out_total_hits,
  output logic [31:0]                out_total_misses,
  output logic [31:0]                out_total_reads,
  output logic [31:0]                out_total_writes
);

  localparam int IDX_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int MEM_AW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] tag;
    logic                 vld;
    logic [AGE_W-1:0]     age;
  } ent_t;

  typedef ent_t [MAX_WAYS-1:0] row_t;

  // configuration
  logic [3:0] ob_r, ib_r;
  logic [4:0] ways_r;
  logic       pf_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_r    <= RST_OFFSET_BITS;
      ib_r    <= RST_INDEX_BITS;
      ways_r  <= RST_WAYS;
      pf_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS: ob_r    <= cfg_data[3:0];
        CFG_INDEX_BITS:  ib_r    <= cfg_data[3:0];
        CFG_WAYS:        ways_r  <= cfg_data;
        CFG_PREFETCH:    pf_en_r <= cfg_data[0];
        default:         pf_en_r <= pf_en_r;
      endcase
    end
  end

  // effective geometry
  logic [4:0] ib_eff;
  logic [6:0] nw;
  assign ib_eff = ({1'b0, ib_r} > 5'(IDX_MAX)) ? 5'(IDX_MAX) : {1'b0, ib_r};
  assign nw = (ways_r == 5'd0) ? 7'd1 :
              ({2'b0, ways_r} > 7'(MAX_WAYS)) ? 7'(MAX_WAYS) : {2'b0, ways_r};

  // access registers
  logic                 act_r;
  logic [ADDR_BITS-1:0] addr_r, next_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      addr_r <= in_address;
      next_r <= in_address + (ADDR_BITS'(1) << ob_r);
    end
  end

  // address split for the current pass
  logic [ADDR_BITS-1:0] cur, set_full, tag;
  logic [5:0]           sh;
  logic [MEM_AW-1:0]    set_idx;
  assign cur      = cmd.pf ? next_r : addr_r;
  assign sh       = {2'b0, ob_r} + {1'b0, ib_eff};
  assign set_full = (cur >> ob_r) & ~({ADDR_BITS{1'b1}} << ib_eff);
  assign set_idx  = set_full[MEM_AW-1:0];
  assign tag      = cur >> sh;

  // clearing pass counter
  logic [MEM_AW-1:0] clr_idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clr_idx_r <= '0;
    else if (cmd.clr) clr_idx_r <= clr_idx_r + 1'b1;
  end
  assign sts.clr_done = (clr_idx_r == MEM_AW'(MAX_SETS - 1));

  // set memory, one row per set
  row_t mem [MAX_SETS];
  row_t row_r, new_row;
  logic mem_we;
  logic hit_r;

  assign mem_we = cmd.clr || (cmd.upd && !(cmd.pf && hit_r));

  always_ff @(posedge clk) begin
    if (mem_we) mem[cmd.clr ? clr_idx_r : set_idx] <= cmd.clr ? row_t'('0) : new_row;
    if (cmd.rd) row_r <= mem[set_idx];
  end

  // lookup: hit way, first free way, oldest way
  logic [MAX_WAYS-1:0] match, free, oldest;
  logic [WAY_W-1:0]    hit_way, free_way, old_way;
  logic                any_hit, any_free;

  always_comb begin
    match    = '0;
    free     = '0;
    oldest   = '0;
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      match[i] = (7'(i) < nw) && row_r[i].vld && (row_r[i].tag == tag);
      free[i]  = (7'(i) < nw) && !row_r[i].vld;
      oldest[i] = (7'(i) < nw);
      for (int j = 0; j < MAX_WAYS; j++) begin
        if ((7'(j) < nw) && (j < i) && !(row_r[i].age > row_r[j].age)) oldest[i] = 1'b0;
        if ((7'(j) < nw) && (j > i) && (row_r[i].age < row_r[j].age)) oldest[i] = 1'b0;
      end
    end
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i])  hit_way  = WAY_W'(i);
      if (free[i])   free_way = WAY_W'(i);
      if (oldest[i]) old_way  = WAY_W'(i);
    end
    any_hit  = |match;
    any_free = |free;
  end

  logic [WAY_W-1:0] way_r;
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      hit_r <= any_hit;
      way_r <= any_hit ? hit_way : (any_free ? free_way : old_way);
    end
  end
  assign sts.hit = hit_r;

  // row update: promote on hit, insert on miss
  always_comb begin
    logic [AGE_W-1:0] a;
    a       = row_r[way_r].age;
    new_row = row_r;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_W'(i) == way_r) begin
        new_row[i].age = '0;
        if (!hit_r) begin
          new_row[i].tag = tag;
          new_row[i].vld = 1'b1;
        end
      end else if ((7'(i) < nw) && row_r[i].vld) begin
        if (hit_r ? (row_r[i].age < a) : (row_r[i].age < AGE_MAX))
          new_row[i].age = row_r[i].age + 1'b1;
      end
    end
  end

  // per-access result
  logic       hit_d_r;
  logic [1:0] reads_r;
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      if (!cmd.pf) begin
        hit_d_r <= hit_r;
        reads_r <= hit_r ? 2'd0 : 2'd1;
      end else if (!hit_r) begin
        reads_r <= 2'd2;
      end
    end
  end

  // running totals and output register
  logic        out_valid_r;
  logic        hit_o_r, wr_o_r;
  logic [1:0]  reads_o_r;
  logic [31:0] hits_r, misses_r, rds_r, wrs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      rds_r       <= '0;
      wrs_r       <= '0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        hits_r      <= hits_r + {31'b0, hit_d_r};
        misses_r    <= misses_r + {31'b0, !hit_d_r};
        rds_r       <= rds_r + {30'b0, reads_r};
        wrs_r       <= wrs_r + {31'b0, act_r};
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit_o_r   <= hit_d_r;
      wr_o_r    <= act_r;
      reads_o_r <= reads_r;
    end
  end

  assign sts.pf_en    = pf_en_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_o_r;
  assign out_reads_caused = reads_o_r;
  assign out_write_caused = wr_o_r;
  assign out_total_hits   = hits_r;
  assign out_total_misses = misses_r;
  assign out_total_reads  = rds_r;
  assign out_total_writes = wrs_r;

endmodule
`default_nettype wire

[design/lru_cache_with_next_line_prefetch_top.sv]
// Sequence: an accepted access steps through read, compare, update and finish before out_valid
// rises; a miss that also fills the next block repeats read, compare and update for it first,
// and a stalled earlier result holds the access in its last state until it drains. A new access
// is taken only once the last has finished; each pass over a set is read, compare and write back.
// Reset: synchronous active-low; counters and configuration reset, then a clearing pass over
// all MAX_SETS sets zeroes the set memory while in_stall stays high.
`include "lru_cache_with_next_line_prefetch_top_defines.svh"
`default_nettype none
module lru_cache_with_next_line_prefetch_top
  import lcp_pkg::*;
#(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 16,
  parameter int ADDR_BITS = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_action,
  input  wire logic [ADDR_BITS-1:0]  in_address,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_hit,
  output logic [1:0]                 out_reads_caused,
  output logic                       out_write_caused,
  output logic [31:0]                out_total_hits,
  output logic [31:0]                out_total_misses,
  output logic [31:0]                out_total_reads,
  output logic [31:0]                out_total_writes
);

  lcp_cmd_t cmd;
  lcp_sts_t sts;

  assign cfg_ready = 1'b1;

  lcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcp_dp #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_address       (in_address),
    .cmd              (cmd),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_reads_caused (out_reads_caused),
    .out_write_caused (out_write_caused),
    .out_total_hits   (out_total_hits),
    .out_total_misses (out_total_misses),
    .out_total_reads  (out_total_reads),
    .out_total_writes (out_total_writes)
  );

  // an accepted access keeps the input closed while it is worked on
  `LCP_ASSERT(a_one_at_a_time, (in_valid && !in_stall) |=> in_stall)
  // a miss always causes at least the demand fill
  `LCP_ASSERT(a_miss_reads, (out_valid && !out_hit) |-> (out_reads_caused != 2'd0))
  // a new hit result moves the hit total by one
  `LCP_ASSERT(a_hit_count, ($rose(out_valid) && out_hit) |-> (out_total_hits == $past(out_total_hits) + 32'd1))

endmodule
`default_nettype wire
